// ----- rtl/msvcf_pkg.sv -----
// Shared types, constants and configuration defaults of the multi-scan voxel
// consistency filter. Every other file of the block depends on this package.
`default_nettype none

package msvcf_pkg;

  // Default grid size and scan count, handed to the top level parameters.
  localparam int GRID_X_DEF    = 128;
  localparam int GRID_Y_DEF    = 64;
  localparam int GRID_Z_DEF    = 32;
  localparam int MAX_SCANS_DEF = 16;

  // Fixed field widths.
  localparam int COORD_W     = 16;
  localparam int SCAN_W      = 4;
  localparam int VSIZE_W     = 12;
  localparam int CFG_DATA_W  = 16;
  localparam int ADDR_OUT_W  = 18;
  localparam int COUNT_OUT_W = 5;
  localparam int THRESH_W    = 5;

  // Axis divider: 16-bit magnitude, four quotient bits per cycle.
  localparam int DIV_W     = 16;
  localparam int DIV_RADIX = 4;
  localparam int DIV_STEPS = DIV_W / DIV_RADIX;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Depth of the queue between front and back, a power of two.
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic {
    REQ_FILL     = 1'b0,
    REQ_CLASSIFY = 1'b1
  } req_t;

  typedef enum logic [2:0] {
    REG_VOXEL_SIZE     = 3'd0,
    REG_ORIGIN_X       = 3'd1,
    REG_ORIGIN_Y       = 3'd2,
    REG_ORIGIN_Z       = 3'd3,
    REG_CELLS_X        = 3'd4,
    REG_CELLS_Y        = 3'd5,
    REG_CELLS_Z        = 3'd6,
    REG_SCAN_THRESHOLD = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    req_t                       req_type;
    logic signed [COORD_W-1:0]  x_mm;
    logic signed [COORD_W-1:0]  y_mm;
    logic signed [COORD_W-1:0]  z_mm;
    logic [SCAN_W-1:0]          scan_index;
  } item_t;

  typedef struct packed {
    logic                       in_range;
    logic [ADDR_OUT_W-1:0]      voxel_address;
    logic [COUNT_OUT_W-1:0]     scan_count;
    logic                       is_consistent;
  } result_t;

  typedef struct packed {
    logic [VSIZE_W-1:0]         voxel_size_mm;
    logic signed [COORD_W-1:0]  origin_x_mm;
    logic signed [COORD_W-1:0]  origin_y_mm;
    logic signed [COORD_W-1:0]  origin_z_mm;
    logic [7:0]                 cells_x;
    logic [6:0]                 cells_y;
    logic [5:0]                 cells_z;
    logic [THRESH_W-1:0]        scan_threshold;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    voxel_size_mm:  12'd400,
    origin_x_mm:    16'(-11000),
    origin_y_mm:    16'(-7000),
    origin_z_mm:    16'(-1000),
    cells_x:        8'd86,
    cells_y:        7'd46,
    cells_z:        6'd18,
    scan_threshold: 5'd1
  };

  typedef enum logic [1:0] {
    FR_IDLE = 2'd0,
    FR_DIV  = 2'd1,
    FR_ADDR = 2'd2
  } front_state_t;

  typedef enum logic [1:0] {
    BK_CLEAR  = 2'd0,
    BK_IDLE   = 2'd1,
    BK_UPDATE = 2'd2
  } back_state_t;

endpackage

`default_nettype wire

// ----- rtl/msvcf_axis_div.sv -----
// Iterative restoring divider for one axis: offset magnitude over voxel size,
// four quotient bits per cycle. Depends on msvcf_pkg.
`default_nettype none

module msvcf_axis_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [msvcf_pkg::DIV_W-1:0]   dividend,
  input  wire logic [msvcf_pkg::VSIZE_W-1:0] divisor,
  output logic      [msvcf_pkg::DIV_W-1:0]   quotient,
  output logic                               last
);

  logic                              running;
  logic [msvcf_pkg::DIV_CNT_W-1:0]   cnt;
  logic [msvcf_pkg::VSIZE_W:0]       rem;
  logic [msvcf_pkg::VSIZE_W:0]       rem_next;
  logic [msvcf_pkg::DIV_W-1:0]       quo;
  logic [msvcf_pkg::DIV_W-1:0]       quo_next;

  // The remainder stays below the divisor, so one spare bit holds the shift.
  always_comb begin
    rem_next = rem;
    quo_next = quo;
    for (int k = 0; k < msvcf_pkg::DIV_RADIX; k++) begin
      rem_next = {rem_next[msvcf_pkg::VSIZE_W-1:0], quo_next[msvcf_pkg::DIV_W-1]};
      quo_next = {quo_next[msvcf_pkg::DIV_W-2:0], 1'b0};
      if (rem_next >= {1'b0, divisor}) begin
        rem_next    = rem_next - {1'b0, divisor};
        quo_next[0] = 1'b1;
      end
    end
  end

  assign last     = running && (cnt == msvcf_pkg::DIV_CNT_W'(msvcf_pkg::DIV_STEPS - 1));
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      cnt     <= '0;
    end else if (start) begin
      running <= 1'b1;
      cnt     <= '0;
    end else if (running) begin
      cnt <= cnt + 1'b1;
      if (last) begin
        running <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (running) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/msvcf_front.sv -----
// Front end: accepts input beats, maps the point to a voxel with three axis
// dividers and pushes the classified item. Depends on msvcf_pkg, msvcf_axis_div.
`default_nettype none

module msvcf_front #(
  parameter int GRID_X = msvcf_pkg::GRID_X_DEF,
  parameter int GRID_Y = msvcf_pkg::GRID_Y_DEF,
  parameter int GRID_Z = msvcf_pkg::GRID_Z_DEF,
  localparam int CELL_TOTAL = GRID_X * GRID_Y * GRID_Z,
  localparam int ADDR_W     = (CELL_TOTAL > 1) ? $clog2(CELL_TOTAL) : 1,
  localparam int QW         = 2 + msvcf_pkg::SCAN_W + ADDR_W
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire msvcf_pkg::cfg_t   cfg,
  input  wire logic              item_valid,
  output logic                   item_stall,
  input  wire msvcf_pkg::item_t  item,
  output logic                   push_valid,
  output logic [QW-1:0]          push_data,
  input  wire logic              push_full
);

  localparam int IX_W = (GRID_X > 1) ? $clog2(GRID_X) : 1;
  localparam int IY_W = (GRID_Y > 1) ? $clog2(GRID_Y) : 1;
  localparam int IZ_W = (GRID_Z > 1) ? $clog2(GRID_Z) : 1;
  localparam logic [ADDR_W-1:0] YZ_C = ADDR_W'(GRID_Y * GRID_Z);
  localparam logic [ADDR_W-1:0] Z_C  = ADDR_W'(GRID_Z);
  localparam int LIM_W = msvcf_pkg::DIV_W + 1;

  msvcf_pkg::front_state_t st;
  msvcf_pkg::front_state_t st_next;

  logic                               accept;
  logic [msvcf_pkg::COORD_W-1:0]      coord  [3];
  logic [msvcf_pkg::COORD_W-1:0]      origin [3];
  logic [msvcf_pkg::COORD_W:0]        off    [3];
  logic [msvcf_pkg::DIV_W-1:0]        mag    [3];
  logic [msvcf_pkg::DIV_W-1:0]        quo    [3];
  logic [LIM_W-1:0]                   cells  [3];
  logic [LIM_W-1:0]                   grid   [3];
  logic [LIM_W-1:0]                   lim    [3];
  logic [2:0]                         last;
  logic [2:0]                         neg;
  logic [2:0]                         axis_ok;
  logic                               in_rng;
  msvcf_pkg::req_t                    req;
  logic [msvcf_pkg::SCAN_W-1:0]       scan;
  logic [ADDR_W-1:0]                  addr;

  assign coord[0]  = item.x_mm;
  assign coord[1]  = item.y_mm;
  assign coord[2]  = item.z_mm;
  assign origin[0] = cfg.origin_x_mm;
  assign origin[1] = cfg.origin_y_mm;
  assign origin[2] = cfg.origin_z_mm;
  assign cells[0]  = LIM_W'(cfg.cells_x);
  assign cells[1]  = LIM_W'(cfg.cells_y);
  assign cells[2]  = LIM_W'(cfg.cells_z);
  assign grid[0]   = LIM_W'(GRID_X);
  assign grid[1]   = LIM_W'(GRID_Y);
  assign grid[2]   = LIM_W'(GRID_Z);

  for (genvar a = 0; a < 3; a++) begin : g_axis
    // The 17-bit difference is exact for any coordinate and origin.
    assign off[a] = {coord[a][msvcf_pkg::COORD_W-1], coord[a]}
                  - {origin[a][msvcf_pkg::COORD_W-1], origin[a]};
    assign mag[a] = off[a][msvcf_pkg::COORD_W] ? msvcf_pkg::DIV_W'(-off[a])
                                               : off[a][msvcf_pkg::DIV_W-1:0];
    assign lim[a] = (cells[a] < grid[a]) ? cells[a] : grid[a];

    // Truncation toward zero puts a point less than one voxel below the
    // origin at index zero, so a negative offset passes only with a zero quotient.
    assign axis_ok[a] = (cfg.voxel_size_mm != '0)
                     && !(neg[a] && (quo[a] != '0))
                     && ({1'b0, quo[a]} < lim[a]);

    msvcf_axis_div u_div (
      .clk      (clk),
      .rst      (rst),
      .start    (accept),
      .dividend (mag[a]),
      .divisor  (cfg.voxel_size_mm),
      .quotient (quo[a]),
      .last     (last[a])
    );
  end

  assign in_rng = &axis_ok;
  assign addr   = ADDR_W'(quo[0][IX_W-1:0]) * YZ_C
                + ADDR_W'(quo[1][IY_W-1:0]) * Z_C
                + ADDR_W'(quo[2][IZ_W-1:0]);

  always_ff @(posedge clk) begin
    if (accept) begin
      neg[0] <= off[0][msvcf_pkg::COORD_W];
      neg[1] <= off[1][msvcf_pkg::COORD_W];
      neg[2] <= off[2][msvcf_pkg::COORD_W];
      req    <= item.req_type;
      scan   <= item.scan_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= msvcf_pkg::FR_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_comb begin
    st_next = st;
    unique case (st)
      msvcf_pkg::FR_IDLE: begin
        if (item_valid) st_next = msvcf_pkg::FR_DIV;
      end
      msvcf_pkg::FR_DIV: begin
        if (last[0]) st_next = msvcf_pkg::FR_ADDR;
      end
      msvcf_pkg::FR_ADDR: begin
        if (!push_full) st_next = msvcf_pkg::FR_IDLE;
      end
      default: st_next = msvcf_pkg::FR_IDLE;
    endcase
  end

  always_comb begin
    item_stall = (st != msvcf_pkg::FR_IDLE);
    accept     = item_valid && !item_stall;
    push_valid = (st == msvcf_pkg::FR_ADDR);
    push_data  = {in_rng, req, scan, in_rng ? addr : {ADDR_W{1'b0}}};
  end

  // The three dividers start together and must finish together.
  a_div_lockstep: assert property (@(posedge clk) disable iff (rst)
    (last == 3'b000) || (last == 3'b111))
    else $error("axis dividers out of step");

  a_div_in_state: assert property (@(posedge clk) disable iff (rst)
    last[0] |-> (st == msvcf_pkg::FR_DIV))
    else $error("divider finished outside the divide state");

endmodule

`default_nettype wire

// ----- rtl/msvcf_queue.sv -----
// Short FIFO of mapped items between the front end and the mask engine.
// Depends on msvcf_pkg for its depth.
`default_nettype none

module msvcf_queue #(
  parameter int W = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push_valid,
  input  wire logic [W-1:0]  push_data,
  output logic               full,
  output logic               head_valid,
  output logic [W-1:0]       head_data,
  input  wire logic          pop
);

  localparam int PTR_W = $clog2(msvcf_pkg::QUEUE_DEPTH);

  logic [W-1:0]     slot [msvcf_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   fill;
  logic             push;
  logic             pop_ok;

  assign full       = (fill == (PTR_W + 1)'(msvcf_pkg::QUEUE_DEPTH));
  assign head_valid = (fill != '0);
  assign head_data  = slot[rd_ptr];
  assign push       = push_valid && !full;
  assign pop_ok     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop_ok) rd_ptr <= rd_ptr + 1'b1;
      fill <= fill + (PTR_W + 1)'(push) - (PTR_W + 1)'(pop_ok);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("queue popped while empty");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= (PTR_W + 1)'(msvcf_pkg::QUEUE_DEPTH))
    else $error("queue fill count beyond depth");

endmodule

`default_nettype wire

// ----- rtl/msvcf_back.sv -----
// Mask engine: clears the voxel mask memory after reset, then does the
// read-modify-write and scan count for each queued item. Depends on msvcf_pkg.
`default_nettype none

module msvcf_back #(
  parameter int GRID_X    = msvcf_pkg::GRID_X_DEF,
  parameter int GRID_Y    = msvcf_pkg::GRID_Y_DEF,
  parameter int GRID_Z    = msvcf_pkg::GRID_Z_DEF,
  parameter int MAX_SCANS = msvcf_pkg::MAX_SCANS_DEF,
  localparam int CELL_TOTAL = GRID_X * GRID_Y * GRID_Z,
  localparam int ADDR_W     = (CELL_TOTAL > 1) ? $clog2(CELL_TOTAL) : 1,
  localparam int QW         = 2 + msvcf_pkg::SCAN_W + ADDR_W
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic [msvcf_pkg::THRESH_W-1:0]  scan_threshold,
  input  wire logic                            head_valid,
  input  wire logic [QW-1:0]                   head_data,
  output logic                                 pop,
  output logic                                 result_valid,
  input  wire logic                            result_stall,
  output msvcf_pkg::result_t                   result
);

  localparam int MASK_W = MAX_SCANS;
  localparam int CNT_W  = $clog2(MAX_SCANS + 1);
  localparam int CMP_W  = (CNT_W > msvcf_pkg::THRESH_W) ? CNT_W : msvcf_pkg::THRESH_W;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELL_TOTAL - 1);

  msvcf_pkg::back_state_t st;
  msvcf_pkg::back_state_t st_next;

  logic [MASK_W-1:0]             mask_mem [CELL_TOTAL];
  logic [MASK_W-1:0]             rdata;
  logic [MASK_W-1:0]             scan_bit;
  logic [MASK_W-1:0]             new_mask;
  logic [CNT_W-1:0]              cnt;
  logic [ADDR_W-1:0]             clear_addr;
  logic                          h_in_range;
  msvcf_pkg::req_t               h_req;
  logic [msvcf_pkg::SCAN_W-1:0]  h_scan;
  logic [ADDR_W-1:0]             h_addr;
  logic                          cur_in_range;
  msvcf_pkg::req_t               cur_req;
  logic [msvcf_pkg::SCAN_W-1:0]  cur_scan;
  logic [ADDR_W-1:0]             cur_addr;
  logic                          out_free;
  logic                          load;
  logic                          we;
  logic [ADDR_W-1:0]             waddr;
  logic [MASK_W-1:0]             wdata;
  logic                          consistent;

  assign h_in_range = head_data[QW-1];
  assign h_req      = msvcf_pkg::req_t'(head_data[QW-2]);
  assign h_scan     = head_data[ADDR_W +: msvcf_pkg::SCAN_W];
  assign h_addr     = head_data[ADDR_W-1:0];

  // Scan numbers at or above MAX_SCANS have no bit in the mask.
  assign scan_bit = (32'(cur_scan) < MAX_SCANS) ? (MASK_W'(1) << cur_scan) : '0;
  assign new_mask = (cur_req == msvcf_pkg::REQ_FILL) ? (rdata | scan_bit) : rdata;

  always_comb begin
    cnt = '0;
    for (int i = 0; i < MASK_W; i++) begin
      cnt = cnt + CNT_W'(new_mask[i]);
    end
  end

  assign consistent = (cur_req == msvcf_pkg::REQ_CLASSIFY)
                   && (CMP_W'(cnt) > CMP_W'(scan_threshold))
                   && ((new_mask & scan_bit) != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= msvcf_pkg::BK_CLEAR;
    end else begin
      st <= st_next;
    end
  end

  always_comb begin
    st_next = st;
    unique case (st)
      msvcf_pkg::BK_CLEAR: begin
        if (clear_addr == LAST_ADDR) st_next = msvcf_pkg::BK_IDLE;
      end
      msvcf_pkg::BK_IDLE: begin
        if (head_valid) st_next = msvcf_pkg::BK_UPDATE;
      end
      msvcf_pkg::BK_UPDATE: begin
        if (out_free) st_next = msvcf_pkg::BK_IDLE;
      end
      default: st_next = msvcf_pkg::BK_CLEAR;
    endcase
  end

  always_comb begin
    out_free = !result_valid || !result_stall;
    pop      = (st == msvcf_pkg::BK_IDLE) && head_valid;
    load     = (st == msvcf_pkg::BK_UPDATE) && out_free;
    we       = (st == msvcf_pkg::BK_CLEAR)
            || (load && cur_in_range && (cur_req == msvcf_pkg::REQ_FILL));
    waddr    = (st == msvcf_pkg::BK_CLEAR) ? clear_addr : cur_addr;
    wdata    = (st == msvcf_pkg::BK_CLEAR) ? '0 : new_mask;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_addr <= '0;
    end else if (st == msvcf_pkg::BK_CLEAR) begin
      clear_addr <= clear_addr + 1'b1;
    end
  end

  // The mask read is issued as the item leaves the queue, so the data is
  // ready in the update cycle.
  always_ff @(posedge clk) begin
    if (pop) begin
      rdata <= mask_mem[h_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mask_mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_in_range <= h_in_range;
      cur_req      <= h_req;
      cur_scan     <= h_scan;
      cur_addr     <= h_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.in_range      <= cur_in_range;
      result.voxel_address <= cur_in_range ? msvcf_pkg::ADDR_OUT_W'(cur_addr) : '0;
      result.scan_count    <= cur_in_range ? msvcf_pkg::COUNT_OUT_W'(cnt) : '0;
      result.is_consistent <= cur_in_range && consistent;
    end
  end

  a_no_result_in_clear: assert property (@(posedge clk) disable iff (rst)
    (st == msvcf_pkg::BK_CLEAR) |-> !result_valid && !pop)
    else $error("mask engine active during clearing pass");

  a_out_of_range_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.in_range) |->
      (result.voxel_address == '0) && (result.scan_count == '0) && !result.is_consistent)
    else $error("out-of-range result carries nonzero fields");

endmodule

`default_nettype wire

// ----- rtl/multi_scan_voxel_consistency_filter.sv -----
// Top level of the multi-scan voxel consistency filter: configuration
// registers, front end, item queue and mask engine. Depends on msvcf_pkg.
//
//   channel   direction  handshake                  payload
//   config    in         cfg_we                     cfg_index, cfg_data
//   item      in         item_valid / item_stall    item   (msvcf_pkg::item_t)
//   result    out        result_valid / result_stall result (msvcf_pkg::result_t)
//
// The front end takes one item at a time: it accepts the item, runs the radix-16
// axis dividers, then forms the address and pushes to the queue, waiting while it is full.
// The mask engine takes one item at a time (memory read, then write and result).
// After reset the mask memory is cleared one entry per cycle, all GRID_X*GRID_Y*GRID_Z
// entries (262144 with default parameters); items still enter until the queue is full.
// A stalled result holds the mask engine; the front end keeps working into the queue.
`default_nettype none

module multi_scan_voxel_consistency_filter #(
  parameter int GRID_X    = msvcf_pkg::GRID_X_DEF,
  parameter int GRID_Y    = msvcf_pkg::GRID_Y_DEF,
  parameter int GRID_Z    = msvcf_pkg::GRID_Z_DEF,
  parameter int MAX_SCANS = msvcf_pkg::MAX_SCANS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire msvcf_pkg::cfg_reg_t                cfg_index,
  input  wire logic [msvcf_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                               item_valid,
  output logic                                    item_stall,
  input  wire msvcf_pkg::item_t                   item,
  output logic                                    result_valid,
  input  wire logic                               result_stall,
  output msvcf_pkg::result_t                      result
);

  localparam int CELL_TOTAL = GRID_X * GRID_Y * GRID_Z;
  localparam int ADDR_W     = (CELL_TOTAL > 1) ? $clog2(CELL_TOTAL) : 1;
  localparam int QW         = 2 + msvcf_pkg::SCAN_W + ADDR_W;

  msvcf_pkg::cfg_t cfg;
  logic            push_valid;
  logic [QW-1:0]   push_data;
  logic            q_full;
  logic            q_valid;
  logic [QW-1:0]   q_data;
  logic            q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= msvcf_pkg::CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        msvcf_pkg::REG_VOXEL_SIZE:     cfg.voxel_size_mm  <= cfg_data[11:0];
        msvcf_pkg::REG_ORIGIN_X:       cfg.origin_x_mm    <= cfg_data;
        msvcf_pkg::REG_ORIGIN_Y:       cfg.origin_y_mm    <= cfg_data;
        msvcf_pkg::REG_ORIGIN_Z:       cfg.origin_z_mm    <= cfg_data;
        msvcf_pkg::REG_CELLS_X:        cfg.cells_x        <= cfg_data[7:0];
        msvcf_pkg::REG_CELLS_Y:        cfg.cells_y        <= cfg_data[6:0];
        msvcf_pkg::REG_CELLS_Z:        cfg.cells_z        <= cfg_data[5:0];
        msvcf_pkg::REG_SCAN_THRESHOLD: cfg.scan_threshold <= cfg_data[4:0];
      endcase
    end
  end

  msvcf_front #(
    .GRID_X (GRID_X),
    .GRID_Y (GRID_Y),
    .GRID_Z (GRID_Z)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_full  (q_full)
  );

  msvcf_queue #(
    .W (QW)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_data),
    .full       (q_full),
    .head_valid (q_valid),
    .head_data  (q_data),
    .pop        (q_pop)
  );

  msvcf_back #(
    .GRID_X    (GRID_X),
    .GRID_Y    (GRID_Y),
    .GRID_Z    (GRID_Z),
    .MAX_SCANS (MAX_SCANS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .scan_threshold (cfg.scan_threshold),
    .head_valid     (q_valid),
    .head_data      (q_data),
    .pop            (q_pop),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .result         (result)
  );

endmodule

`default_nettype wire
